// File: rtl/fpts_pkg.sv
// Shared types and constants for the fixed-priority task scheduler.
// Holds operation, task status and controller state codes, and the
// command and status bundles between controller and datapath. No dependencies.
package fpts_pkg;

    localparam int MAX_TASKS_DEF   = 8;
    localparam int LOWEST_PRIO_DEF = 4;
    localparam int TICK_BITS_DEF   = 32;

    localparam int OP_W    = 3;
    localparam int PRIO_W  = 3;
    localparam int DELAY_W = 32;
    localparam int TICK_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_TICK     = 3'd1,
        OP_DELAY    = 3'd2,
        OP_SUSPEND  = 3'd3,
        OP_ACTIVATE = 3'd4,
        OP_START    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_READY     = 2'd0,
        ST_RUNNING   = 2'd1,
        ST_WAITING   = 2'd2,
        ST_SUSPENDED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CTL_IDLE   = 2'd0,
        CTL_APPLY  = 2'd1,
        CTL_SCAN   = 2'd2,
        CTL_COMMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

// File: rtl/fixed_priority_task_scheduler_core.sv
// Top level of the fixed-priority preemptive task scheduler.
// Instantiates fpts_ctrl and fpts_datapath; uses fpts_pkg for types and defaults.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_op, s_prio, s_delay_ticks, s_target_task
//  m_       | out       | m_valid / m_ready  | m_running_task, m_switch_needed,
//           |           |                    | m_tick_count, m_new_handle, m_table_full
//
// An item is captured, its operation is applied to the task table, the dispatch scan
// reads one table slot a cycle from slot 0 up to slot task_total, and the result is
// committed.
// Reset (aresetn low, synchronous) empties the table, zeroes the tick clock and marks
// every slot ready; the priority store is not cleared.
// A held result does not stop the next transfer; only the commit of that next item
// waits for the output register to drain.
module fixed_priority_task_scheduler_core #(
    parameter  int MAX_TASKS       = fpts_pkg::MAX_TASKS_DEF,
    parameter  int LOWEST_PRIORITY = fpts_pkg::LOWEST_PRIO_DEF,
    parameter  int TICK_BITS       = fpts_pkg::TICK_BITS_DEF,
    localparam int IDX_W           = $clog2(MAX_TASKS + 1),
    localparam int HANDLE_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fpts_pkg::OP_W-1:0]    s_op,
    input  logic [fpts_pkg::PRIO_W-1:0]  s_prio,
    input  logic [fpts_pkg::DELAY_W-1:0] s_delay_ticks,
    input  logic [HANDLE_W-1:0]          s_target_task,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [IDX_W-1:0]             m_running_task,
    output logic                         m_switch_needed,
    output logic [fpts_pkg::TICK_W-1:0]  m_tick_count,
    output logic [HANDLE_W-1:0]          m_new_handle,
    output logic                         m_table_full
);

    fpts_pkg::cmd_t cmd;
    fpts_pkg::sts_t sts;

    // sequencing: capture, apply, scan, commit
    fpts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // task table, tick clock, scan registers and result register
    fpts_datapath #(
        .MAX_TASKS       (MAX_TASKS),
        .LOWEST_PRIORITY (LOWEST_PRIORITY),
        .TICK_BITS       (TICK_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_prio          (s_prio),
        .s_delay_ticks   (s_delay_ticks),
        .s_target_task   (s_target_task),
        .m_running_task  (m_running_task),
        .m_switch_needed (m_switch_needed),
        .m_tick_count    (m_tick_count),
        .m_new_handle    (m_new_handle),
        .m_table_full    (m_table_full)
    );

endmodule

// File: rtl/fpts_ctrl.sv
// Sequencing state machine for the task scheduler.
// Depends on fpts_pkg for state, command and status types.
module fpts_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  fpts_pkg::sts_t sts,
    output fpts_pkg::cmd_t cmd
);

    fpts_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fpts_pkg::CTL_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fpts_pkg::CTL_IDLE: begin
                if (s_valid) state_next = fpts_pkg::CTL_APPLY;
            end
            fpts_pkg::CTL_APPLY: begin
                state_next = fpts_pkg::CTL_SCAN;
            end
            fpts_pkg::CTL_SCAN: begin
                if (sts.scan_last) state_next = fpts_pkg::CTL_COMMIT;
            end
            fpts_pkg::CTL_COMMIT: begin
                if (out_free) state_next = fpts_pkg::CTL_IDLE;
            end
            default: state_next = fpts_pkg::CTL_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd            = '0;
        s_ready        = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        unique case (state_reg)
            fpts_pkg::CTL_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            fpts_pkg::CTL_APPLY: begin
                cmd.apply = 1'b1;
            end
            fpts_pkg::CTL_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            fpts_pkg::CTL_COMMIT: begin
                cmd.commit = out_free;
                if (out_free) out_valid_next = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

    a_commit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fpts_pkg::CTL_COMMIT && out_valid_reg && !m_ready)
        |=> state_reg == fpts_pkg::CTL_COMMIT)
        else $error("commit left while the output register was still full");

    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == fpts_pkg::CTL_COMMIT))
        else $error("result raised outside the commit step");

    a_accept_applies: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == fpts_pkg::CTL_APPLY)
        else $error("accepted transfer not followed by the apply step");

endmodule

// File: rtl/fpts_datapath.sv
// Task table, tick clock, dispatch scan and result register of the scheduler.
// Depends on fpts_pkg for codes and for the command and status bundles.
module fpts_datapath #(
    parameter  int MAX_TASKS       = fpts_pkg::MAX_TASKS_DEF,
    parameter  int LOWEST_PRIORITY = fpts_pkg::LOWEST_PRIO_DEF,
    parameter  int TICK_BITS       = fpts_pkg::TICK_BITS_DEF,
    localparam int IDX_W           = $clog2(MAX_TASKS + 1),
    localparam int HANDLE_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fpts_pkg::cmd_t               cmd,
    output fpts_pkg::sts_t               sts,
    input  logic [fpts_pkg::OP_W-1:0]    s_op,
    input  logic [fpts_pkg::PRIO_W-1:0]  s_prio,
    input  logic [fpts_pkg::DELAY_W-1:0] s_delay_ticks,
    input  logic [HANDLE_W-1:0]          s_target_task,
    output logic [IDX_W-1:0]             m_running_task,
    output logic                         m_switch_needed,
    output logic [fpts_pkg::TICK_W-1:0]  m_tick_count,
    output logic [HANDLE_W-1:0]          m_new_handle,
    output logic                         m_table_full
);

    localparam int PW = ($clog2(LOWEST_PRIORITY + 1) > fpts_pkg::PRIO_W) ?
                        $clog2(LOWEST_PRIORITY + 1) : fpts_pkg::PRIO_W;

    // captured item
    fpts_pkg::op_t                op_reg;
    logic [fpts_pkg::PRIO_W-1:0]  prio_in_reg;
    logic [fpts_pkg::DELAY_W-1:0] delay_reg;
    logic [HANDLE_W-1:0]          target_reg;

    // task table
    logic [PW-1:0]                prio_mem_reg [0:MAX_TASKS];
    fpts_pkg::status_t            status_reg   [0:MAX_TASKS];
    logic [fpts_pkg::DELAY_W-1:0] wait_reg     [0:MAX_TASKS-1];
    logic [IDX_W-1:0]             total_reg;
    logic [IDX_W-1:0]             cur_reg;
    logic [TICK_BITS-1:0]         clock_reg;
    logic                         first_reg;
    logic                         idle_valid_reg;   // slot total_reg holds a started idle task

    // per-item results
    logic [HANDLE_W-1:0]          handle_reg;
    logic                         full_reg;

    // dispatch scan
    logic [IDX_W-1:0]             scan_idx_reg;
    logic [IDX_W-1:0]             best_idx_reg;
    logic [PW-1:0]                best_prio_reg;
    logic                         found_reg;

    logic [IDX_W-1:0]             target_ext;
    logic                         target_written;
    logic                         target_ok;
    logic                         total_lt_max;
    logic                         cur_lt_max;
    logic                         scan_written;
    logic [PW-1:0]                scan_prio;
    fpts_pkg::status_t            scan_st;
    logic                         scan_take;
    logic                         change;

    assign total_lt_max   = total_reg < IDX_W'(MAX_TASKS);
    assign cur_lt_max     = cur_reg < IDX_W'(MAX_TASKS);
    assign target_ext     = IDX_W'(target_reg);
    assign target_written = (target_ext < total_reg) || idle_valid_reg;
    assign target_ok      = (target_ext <= total_reg) && target_written &&
                            (status_reg[target_ext] == fpts_pkg::ST_WAITING ||
                             status_reg[target_ext] == fpts_pkg::ST_SUSPENDED);

    assign scan_written = (scan_idx_reg < total_reg) || idle_valid_reg;
    assign scan_prio    = prio_mem_reg[scan_idx_reg];
    assign scan_st      = status_reg[scan_idx_reg];
    assign scan_take    = scan_written && (scan_prio <= PW'(LOWEST_PRIORITY)) &&
                          (scan_st == fpts_pkg::ST_READY || scan_st == fpts_pkg::ST_RUNNING) &&
                          (!found_reg || scan_prio < best_prio_reg);
    assign sts.scan_last = scan_idx_reg == total_reg;
    assign change        = found_reg && (best_idx_reg != cur_reg);

    // capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= fpts_pkg::op_t'(s_op);
            prio_in_reg <= s_prio;
            delay_reg   <= s_delay_ticks;
            target_reg  <= s_target_task;
        end
    end

    // control registers of the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg      <= '0;
            cur_reg        <= '0;
            clock_reg      <= '0;
            first_reg      <= 1'b1;
            idle_valid_reg <= 1'b0;
        end else if (cmd.apply) begin
            unique case (op_reg)
                fpts_pkg::OP_CREATE: begin
                    if (total_lt_max) begin
                        total_reg      <= total_reg + IDX_W'(1);
                        idle_valid_reg <= 1'b0;
                    end
                end
                fpts_pkg::OP_TICK: begin
                    clock_reg <= clock_reg + TICK_BITS'(1);
                end
                fpts_pkg::OP_START: begin
                    idle_valid_reg <= 1'b1;
                end
                default: begin
                    idle_valid_reg <= idle_valid_reg;
                end
            endcase
        end else if (cmd.commit) begin
            if (change) first_reg <= 1'b0;
            if (found_reg) cur_reg <= best_idx_reg;
        end
    end

    // priorities: written by create and start only
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            if (op_reg == fpts_pkg::OP_CREATE && total_lt_max)
                prio_mem_reg[total_reg] <= PW'(prio_in_reg);
            else if (op_reg == fpts_pkg::OP_START)
                prio_mem_reg[total_reg] <= PW'(LOWEST_PRIORITY);
        end
    end

    // status table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= MAX_TASKS; i++) status_reg[i] <= fpts_pkg::ST_READY;
        end else if (cmd.apply) begin
            unique case (op_reg)
                fpts_pkg::OP_CREATE: begin
                    if (total_lt_max) status_reg[total_reg] <= fpts_pkg::ST_READY;
                end
                fpts_pkg::OP_TICK: begin
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (status_reg[i] == fpts_pkg::ST_WAITING &&
                            wait_reg[i] == fpts_pkg::DELAY_W'(1))
                            status_reg[i] <= fpts_pkg::ST_READY;
                    end
                end
                fpts_pkg::OP_DELAY: begin
                    if (cur_lt_max && delay_reg != '0)
                        status_reg[cur_reg] <= fpts_pkg::ST_WAITING;
                end
                fpts_pkg::OP_SUSPEND: begin
                    status_reg[cur_reg] <= fpts_pkg::ST_SUSPENDED;
                end
                fpts_pkg::OP_ACTIVATE: begin
                    if (target_ok) status_reg[target_ext] <= fpts_pkg::ST_READY;
                end
                fpts_pkg::OP_START: begin
                    status_reg[total_reg] <= fpts_pkg::ST_READY;
                end
                default: begin
                    status_reg[cur_reg] <= status_reg[cur_reg];
                end
            endcase
        end else if (cmd.commit && found_reg) begin
            if (change && status_reg[cur_reg] == fpts_pkg::ST_RUNNING)
                status_reg[cur_reg] <= fpts_pkg::ST_READY;
            status_reg[best_idx_reg] <= fpts_pkg::ST_RUNNING;
        end
    end

    // delay counters
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            unique case (op_reg)
                fpts_pkg::OP_CREATE: begin
                    if (total_lt_max) wait_reg[total_reg[HANDLE_W-1:0]] <= '0;
                end
                fpts_pkg::OP_TICK: begin
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (status_reg[i] == fpts_pkg::ST_WAITING)
                            wait_reg[i] <= wait_reg[i] - fpts_pkg::DELAY_W'(1);
                    end
                end
                fpts_pkg::OP_DELAY: begin
                    if (cur_lt_max && delay_reg != '0)
                        wait_reg[cur_reg[HANDLE_W-1:0]] <= delay_reg;
                end
                fpts_pkg::OP_ACTIVATE: begin
                    if (target_ok && target_ext < IDX_W'(MAX_TASKS))
                        wait_reg[target_reg] <= '0;
                end
                fpts_pkg::OP_START: begin
                    if (total_lt_max) wait_reg[total_reg[HANDLE_W-1:0]] <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // per-item create result
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            handle_reg <= '0;
            full_reg   <= 1'b0;
            if (op_reg == fpts_pkg::OP_CREATE) begin
                if (total_lt_max) handle_reg <= total_reg[HANDLE_W-1:0];
                else              full_reg   <= 1'b1;
            end
        end
    end

    // dispatch scan: one slot a cycle, strict compare keeps the lowest index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.apply) begin
            found_reg <= 1'b0;
        end else if (cmd.scan_step && scan_take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            scan_idx_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (scan_take) begin
                best_idx_reg  <= scan_idx_reg;
                best_prio_reg <= scan_prio;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_running_task  <= found_reg ? best_idx_reg : cur_reg;
            m_switch_needed <= change && !first_reg;
            m_tick_count    <= fpts_pkg::TICK_W'(clock_reg);
            m_new_handle    <= handle_reg;
            m_table_full    <= full_reg;
        end
    end

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= IDX_W'(MAX_TASKS))
        else $error("task count beyond the table");

    a_cur_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= IDX_W'(MAX_TASKS))
        else $error("current task index beyond the table");

    a_pick_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && found_reg) |=>
        (cur_reg == $past(best_idx_reg) && status_reg[cur_reg] == fpts_pkg::ST_RUNNING))
        else $error("dispatched task not marked running");

    a_no_pick_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && !found_reg) |=> (cur_reg == $past(cur_reg) && !m_switch_needed))
        else $error("current task moved without a candidate");

endmodule

// File: dv/fpts_dispatch_sb_pkg.sv
// Scoreboard for the fixed-priority task scheduler: a cycle-free predictor of the
// task table and dispatch, plus the queue of predicted dispatch results.
// Depends on fpts_pkg for operation and task status codes.
package fpts_dispatch_sb_pkg;

    localparam int SLOTS  = fpts_pkg::MAX_TASKS_DEF;
    localparam int LOWEST = fpts_pkg::LOWEST_PRIO_DEF;

    typedef struct packed {
        logic [3:0]  running_task;
        logic        switch_needed;
        logic [31:0] tick_count;
        logic [2:0]  new_handle;
        logic        table_full;
    } dispatch_t;

    class dispatch_scoreboard;

        logic [2:0]        slot_prio    [SLOTS+1];
        bit                slot_written [SLOTS+1];
        fpts_pkg::status_t slot_status  [SLOTS+1];
        logic [31:0]       wait_left    [SLOTS];
        int unsigned       task_total;
        int unsigned       current;
        logic [31:0]       tick_clock;
        bit                first_pick;
        dispatch_t         pending_dispatch [$];
        int unsigned       mismatches;

        function new();
            for (int i = 0; i <= SLOTS; i++) begin
                slot_prio[i]    = '0;
                slot_written[i] = 1'b0;
                slot_status[i]  = fpts_pkg::ST_READY;
            end
            for (int i = 0; i < SLOTS; i++) begin
                wait_left[i] = '0;
            end
            task_total = 0;
            current    = 0;
            tick_clock = '0;
            first_pick = 1'b1;
            mismatches = 0;
        endfunction

        // Apply one operation to the table, then dispatch; queue the outcome.
        function void note_request(logic [2:0] op, logic [2:0] prio, logic [31:0] delay,
                                   logic [2:0] target);
            dispatch_t   res;
            int unsigned pick;
            bit          found;
            res   = '0;
            pick  = 0;
            found = 1'b0;
            case (op)
                fpts_pkg::OP_CREATE: begin
                    if (task_total >= SLOTS) begin
                        res.table_full = 1'b1;
                    end else begin
                        slot_prio[task_total]    = prio;
                        slot_written[task_total] = 1'b1;
                        slot_status[task_total]  = fpts_pkg::ST_READY;
                        wait_left[task_total]    = '0;
                        res.new_handle           = 3'(task_total);
                        task_total++;
                    end
                end
                fpts_pkg::OP_TICK: begin
                    tick_clock = tick_clock + 32'd1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_status[i] == fpts_pkg::ST_WAITING) begin
                            wait_left[i] = wait_left[i] - 32'd1;
                            if (wait_left[i] == '0) slot_status[i] = fpts_pkg::ST_READY;
                        end
                    end
                end
                fpts_pkg::OP_DELAY: begin
                    if (current < SLOTS && delay != '0) begin
                        slot_status[current] = fpts_pkg::ST_WAITING;
                        wait_left[current]   = delay;
                    end
                end
                fpts_pkg::OP_SUSPEND: begin
                    if (current <= SLOTS) slot_status[current] = fpts_pkg::ST_SUSPENDED;
                end
                fpts_pkg::OP_ACTIVATE: begin
                    if (target <= task_total && slot_written[target] &&
                        (slot_status[target] == fpts_pkg::ST_WAITING ||
                         slot_status[target] == fpts_pkg::ST_SUSPENDED)) begin
                        slot_status[target] = fpts_pkg::ST_READY;
                        if (target < SLOTS) wait_left[target] = '0;
                    end
                end
                fpts_pkg::OP_START: begin
                    if (task_total <= SLOTS) begin
                        slot_prio[task_total]    = 3'(LOWEST);
                        slot_written[task_total] = 1'b1;
                        slot_status[task_total]  = fpts_pkg::ST_READY;
                        if (task_total < SLOTS) wait_left[task_total] = '0;
                    end
                end
                default: ;
            endcase

            for (int p = 0; p <= LOWEST && !found; p++) begin
                for (int i = 0; i <= task_total && i <= SLOTS && !found; i++) begin
                    if (slot_written[i] && slot_prio[i] == p &&
                        (slot_status[i] == fpts_pkg::ST_READY ||
                         slot_status[i] == fpts_pkg::ST_RUNNING)) begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
            if (found) begin
                if (pick != current) begin
                    if (first_pick) first_pick = 1'b0;
                    else res.switch_needed = 1'b1;
                    if (current <= SLOTS && slot_status[current] == fpts_pkg::ST_RUNNING)
                        slot_status[current] = fpts_pkg::ST_READY;
                end
                current            = pick;
                slot_status[pick]  = fpts_pkg::ST_RUNNING;
            end
            res.running_task = 4'(current);
            res.tick_count   = tick_clock;
            pending_dispatch.push_back(res);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(dispatch_t got);
            dispatch_t want;
            if (pending_dispatch.size() == 0) begin
                $error("dispatch result transfer with nothing outstanding");
                mismatches++;
                return;
            end
            want = pending_dispatch.pop_front();
            compare_field("running_task", 32'(want.running_task), 32'(got.running_task));
            compare_field("switch_needed", 32'(want.switch_needed), 32'(got.switch_needed));
            compare_field("tick_count", want.tick_count, got.tick_count);
            compare_field("new_handle", 32'(want.new_handle), 32'(got.new_handle));
            compare_field("table_full", 32'(want.table_full), 32'(got.table_full));
        endfunction

        function int unsigned outstanding();
            return pending_dispatch.size();
        endfunction

    endclass

endpackage

// File: dv/tb_top.sv
// Top-level testbench for fixed_priority_task_scheduler_core: drives scheduler
// operations over valid/ready and checks every dispatch result.
// Depends on fpts_pkg and fpts_dispatch_sb_pkg.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    // Cycle budget for the whole run, with wide room for stalls on both sides.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;
    // Op codes the block does not define; the table must stay untouched.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op            = '0;
    logic [2:0]  s_prio          = '0;
    logic [31:0] s_delay_ticks   = '0;
    logic [2:0]  s_target_task   = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [3:0]  m_running_task;
    logic        m_switch_needed;
    logic [31:0] m_tick_count;
    logic [2:0]  m_new_handle;
    logic        m_table_full;

    fpts_dispatch_sb_pkg::dispatch_scoreboard sched_sb;
    // Cleared for a stretch of the random part: no idling on either side.
    bit                 gaps_on     = 1'b1;
    int unsigned        cycle_count = 0;

    fixed_priority_task_scheduler_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_prio          (s_prio),
        .s_delay_ticks   (s_delay_ticks),
        .s_target_task   (s_target_task),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_running_task  (m_running_task),
        .m_switch_needed (m_switch_needed),
        .m_tick_count    (m_tick_count),
        .m_new_handle    (m_new_handle),
        .m_table_full    (m_table_full)
    );

    always begin
        #5ns aclk = 1'b1;
        #5ns aclk = 1'b0;
    end

    // Present one operation at the falling edge, optionally after random idle
    // cycles, hold it until the transfer and hand it to the predictor.
    task automatic send_request(input logic [2:0] op, input logic [2:0] prio,
                                input logic [31:0] delay, input logic [2:0] target);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 24) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_op          = op;
        s_prio        = prio;
        s_delay_ticks = delay;
        s_target_task = target;
        do @(posedge aclk); while (!s_ready);
        sched_sb.note_request(op, prio, delay, target);
    endtask

    // Drop valid and hold off until every predicted result has been seen.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sched_sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Pick a random operation. Mostly ticks, delays, suspends and activates so
    // the tasks cycle through waiting, suspended and running; unused fields
    // carry random noise.
    task automatic random_request();
        int unsigned roll;
        int unsigned pick;
        logic [2:0]  op;
        logic [31:0] delay;
        roll = $urandom_range(0, 99);
        if (roll < 5)        op = fpts_pkg::OP_CREATE;
        else if (roll < 35)  op = fpts_pkg::OP_TICK;
        else if (roll < 55)  op = fpts_pkg::OP_DELAY;
        else if (roll < 70)  op = fpts_pkg::OP_SUSPEND;
        else if (roll < 88)  op = fpts_pkg::OP_ACTIVATE;
        else if (roll < 94)  op = fpts_pkg::OP_START;
        else if (roll < 97)  op = OP_SPARE_LO;
        else                 op = OP_SPARE_HI;
        // Short delays let the ticks wake tasks up; long ones need an activate.
        pick = $urandom_range(0, 99);
        if (pick < 55)       delay = 32'($urandom_range(1, 6));
        else if (pick < 65)  delay = '0;
        else if (pick < 80)  delay = 32'($urandom_range(1, 40));
        else                 delay = $urandom();
        send_request(op, 3'($urandom_range(0, 7)), delay, 3'($urandom_range(0, 7)));
    endtask

    // Result side: change ready at the falling edge, sample at the rising edge.
    initial begin
        forever begin
            @(negedge aclk);
            m_ready = !gaps_on || ($urandom_range(0, 99) >= 24);
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sched_sb.check_result('{running_task:  m_running_task,
                                        switch_needed: m_switch_needed,
                                        tick_count:    m_tick_count,
                                        new_handle:    m_new_handle,
                                        table_full:    m_table_full});
            end
        end
    end

    // Watchdog: end the run if it overstays the cycle budget.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("fixed_priority_task_scheduler_core regression: fail");
        $finish;
    end

    initial begin
        sched_sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Operations on an empty table: nothing can be dispatched yet.
        send_request(fpts_pkg::OP_TICK,     3'd0, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_DELAY,    3'd7, 32'hFFFF_FFFF, 3'd7);
        send_request(fpts_pkg::OP_SUSPEND,  3'd0, 32'd0,         3'd0);
        // Target beyond the table: ignore.
        send_request(fpts_pkg::OP_ACTIVATE, 3'd0, 32'd0,         3'd7);
        send_request(OP_SPARE_LO,           3'd5, 32'h5555_5555, 3'd5);
        send_request(OP_SPARE_HI,           3'd2, 32'hAAAA_AAAA, 3'd2);
        // Start on an empty table puts the idle task in slot 0; the choice
        // equals the current index so the first dispatch is still pending.
        send_request(fpts_pkg::OP_START,    3'd0, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_ACTIVATE, 3'd0, 32'd0,         3'd0);
        // Create after start takes over the idle slot.
        send_request(fpts_pkg::OP_CREATE,   3'd3, 32'd0,         3'd0);
        // Priority beyond the lowest level: never chosen.
        send_request(fpts_pkg::OP_CREATE,   3'd7, 32'd0,         3'd0);
        // Top priority task: first change of task, so no switch reported.
        send_request(fpts_pkg::OP_CREATE,   3'd0, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_START,    3'd0, 32'd0,         3'd0);
        // Zero delay leaves the running task alone.
        send_request(fpts_pkg::OP_DELAY,    3'd0, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_DELAY,    3'd0, 32'd2,         3'd0);
        send_request(fpts_pkg::OP_TICK,     3'd0, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_TICK,     3'd0, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_SUSPEND,  3'd0, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_ACTIVATE, 3'd0, 32'd0,         3'd2);
        send_request(fpts_pkg::OP_DELAY,    3'd0, 32'hFFFF_FFFF, 3'd0);
        // Activate a waiting task: clear its count.
        send_request(fpts_pkg::OP_ACTIVATE, 3'd0, 32'd0,         3'd2);
        // Fill the table, then try once more on a full table.
        send_request(fpts_pkg::OP_CREATE,   3'd5, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_CREATE,   3'd1, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_CREATE,   3'd2, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_CREATE,   3'd4, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_CREATE,   3'd6, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_CREATE,   3'd0, 32'd0,         3'd0);
        // Start with a full table: idle task goes into the extra slot.
        send_request(fpts_pkg::OP_START,    3'd0, 32'd0,         3'd0);
        send_request(fpts_pkg::OP_ACTIVATE, 3'd0, 32'd0,         3'd1);

        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on = !(n >= 250 && n < 400);
            if (n == 500) hold_until_drained();
            random_request();
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (sched_sb.outstanding() != 0) @(posedge aclk);
        // Watch for any stray result after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sched_sb.mismatches == 0 && sched_sb.outstanding() == 0) begin
            $display("fixed_priority_task_scheduler_core regression: pass");
        end else begin
            $display("fixed_priority_task_scheduler_core regression: fail");
        end
        $finish;
    end

endmodule
